// ===== hw/rtl/sorm_pkg.sv =====
// shared constants and types for the spin overlap running mean block
// no dependencies; imported by the channel interfaces and all modules but sorm_agree_serial

package sorm_pkg;

   localparam int SPIN_W        = 64;
   localparam int INST_COUNT_W  = 9;
   localparam int QUBIT_COUNT_W = 13;
   localparam int CSR_DATA_W    = 13;
   localparam int CSR_INDEX_W   = 1;
   localparam int INDEX_W       = 8;
   localparam int AGREE_W       = 13;
   localparam int FRAC_BITS     = 16;
   localparam int RATIO_W       = FRAC_BITS + 1;
   localparam int SWEEP_OUT_W   = 20;

   localparam logic [INST_COUNT_W-1:0]  INST_COUNT_RESET  = 9'd1;
   localparam logic [QUBIT_COUNT_W-1:0] QUBIT_COUNT_RESET = 13'd64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INSTANCE_COUNT = 1'b0,
      CSR_QUBIT_COUNT    = 1'b1
   } csr_index_type;

endpackage

// ===== hw/rtl/sorm_ifs.sv =====
// valid/ready channel interfaces for the request and response sides
// depends on sorm_pkg for field widths

interface sorm_req_if import sorm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SPIN_W-1:0] spins_a;
   logic [SPIN_W-1:0] spins_b;

   modport source (output valid, output spins_a, output spins_b, input ready);
   modport sink (input valid, input spins_a, input spins_b, output ready);
endinterface

interface sorm_rsp_if import sorm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [INDEX_W-1:0]     instance_index;
   logic [AGREE_W-1:0]     agree_count;
   logic [RATIO_W-1:0]     overlap_fraction;
   logic [RATIO_W-1:0]     mean_fraction;
   logic [SWEEP_OUT_W-1:0] sweep_index;

   modport source (output valid, output instance_index, output agree_count,
                   output overlap_fraction, output mean_fraction, output sweep_index,
                   input ready);
   modport sink (input valid, input instance_index, input agree_count,
                 input overlap_fraction, input mean_fraction, input sweep_index,
                 output ready);
endinterface

// ===== hw/rtl/spin_overlap_running_mean.sv =====
// Spin overlap counter with running mean over sweeps. Each request carries one chunk of two
// replicas; the agreeing spins are counted one bit per cycle, over the spins the chunk holds
// below qubit_count (at most CHUNK_BITS). After the last chunk of an instance the
// per-instance sum is read, updated and, unless the sweep count has saturated, written back
// in the sum memory, and two 16-step serial dividers form the overlap and mean fractions
// before the response is registered. The response register lets the next request in while a
// response waits. After reset a clearing pass zeroes the sum memory before the first request
// is taken; register writes are accepted throughout.
// depends on sorm_pkg, sorm_ifs, sorm_agree_serial and sorm_q16_div

module spin_overlap_running_mean import sorm_pkg::*; #(
   parameter int MAX_INSTANCES = 256,
   parameter int MAX_QUBITS    = 4096,
   parameter int CHUNK_BITS    = 64,
   parameter int SWEEP_BITS    = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   sorm_req_if.sink               req_bus,
   sorm_rsp_if.source             rsp_bus
);

   localparam int IW    = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
   localparam int QW    = $clog2(MAX_QUBITS + 1);
   localparam int CW    = $clog2(CHUNK_BITS + 1);
   localparam int SUM_W = SWEEP_BITS + QW;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_COUNT, ST_READ, ST_UPDATE, ST_START, ST_DIVIDE, ST_EMIT
   } state_type;

   state_type                state_ff;
   logic [INST_COUNT_W-1:0]  inst_count_ff;
   logic [QUBIT_COUNT_W-1:0] qubit_count_ff;
   logic [QW-1:0]            base_ff;
   logic                     last_chunk_ff;
   logic [IW-1:0]            inst_pos_ff;
   logic [SWEEP_BITS-1:0]    sweep_ff;
   logic [IW-1:0]            clr_ff;
   logic [IW-1:0]            inst_sel_ff;
   logic [QW-1:0]            agree_ff;
   logic [SUM_W-1:0]         sum_rd_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic [SUM_W-1:0]         den_ff;
   logic [SWEEP_BITS-1:0]    sweep_out_ff;
   logic                     rsp_valid_ff;
   logic [INDEX_W-1:0]       rsp_index_ff;
   logic [AGREE_W-1:0]       rsp_agree_ff;
   logic [RATIO_W-1:0]       rsp_overlap_ff;
   logic [RATIO_W-1:0]       rsp_mean_ff;
   logic [SWEEP_OUT_W-1:0]   rsp_sweep_ff;

   logic [SUM_W-1:0] sum_mem [MAX_INSTANCES];

   logic [QW-1:0]         q_eff;
   logic [QW-1:0]         q_rem;
   logic [CW-1:0]         chunk_valid;
   logic                  is_last;
   logic [IW-1:0]         last_inst;
   logic [IW-1:0]         inst_eff;
   logic                  saturated;
   logic [SWEEP_BITS-1:0] n_sweeps;
   logic [SUM_W-1:0]      sum_new;
   logic [CHUNK_BITS-1:0] chunk_same;
   logic                  pop_load;
   logic                  pop_clear;
   logic                  pop_busy;
   logic [QW-1:0]         pop_count;
   logic                  div_start;
   logic                  div_o_done;
   logic                  div_m_done;
   logic [RATIO_W-1:0]    div_o_q;
   logic [RATIO_W-1:0]    div_m_q;
   logic                  mem_we;
   logic [IW-1:0]         mem_waddr;
   logic [SUM_W-1:0]      mem_wdata;
   logic                  rsp_load;

   // effective register values, out-of-range writes clamped
   always_comb begin
      if (qubit_count_ff == '0) begin
         q_eff = QW'(1);
      end else if (32'(qubit_count_ff) > 32'(MAX_QUBITS)) begin
         q_eff = QW'(MAX_QUBITS);
      end else begin
         q_eff = QW'(qubit_count_ff);
      end
      if (inst_count_ff == '0) begin
         last_inst = '0;
      end else if (32'(inst_count_ff) > 32'(MAX_INSTANCES)) begin
         last_inst = IW'(MAX_INSTANCES - 1);
      end else begin
         last_inst = IW'(inst_count_ff - INST_COUNT_W'(1));
      end
      inst_eff = (inst_pos_ff > last_inst) ? last_inst : inst_pos_ff;
   end

   // spins of this chunk that fall below qubit_count
   always_comb begin
      q_rem = q_eff - base_ff;
      if (base_ff >= q_eff) begin
         chunk_valid = '0;
      end else if (32'(q_rem) > 32'(CHUNK_BITS)) begin
         chunk_valid = CW'(CHUNK_BITS);
      end else begin
         chunk_valid = CW'(q_rem);
      end
      is_last    = (({1'b0, base_ff} + (QW+1)'(CHUNK_BITS)) >= {1'b0, q_eff});
      chunk_same = ~(req_bus.spins_a[CHUNK_BITS-1:0] ^ req_bus.spins_b[CHUNK_BITS-1:0]);
   end

   always_comb begin
      saturated = &sweep_ff;
      n_sweeps  = saturated ? sweep_ff : sweep_ff + SWEEP_BITS'(1);
      sum_new   = sum_rd_ff + SUM_W'(agree_ff);
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign pop_load      = (state_ff == ST_IDLE) && req_bus.valid;
   assign pop_clear     = (state_ff == ST_UPDATE);
   assign div_start     = (state_ff == ST_START);
   assign rsp_load      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_bus.ready);

   sorm_agree_serial #(
      .CHUNK_BITS (CHUNK_BITS),
      .CNT_W      (QW)
   ) u_agree (
      .clock      (clock),
      .reset      (reset),
      .load       (pop_load),
      .clear      (pop_clear),
      .same_bits  (chunk_same),
      .valid_bits (chunk_valid),
      .busy       (pop_busy),
      .count      (pop_count)
   );

   sorm_q16_div #(
      .W (QW)
   ) u_div_overlap (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (agree_ff),
      .den      (q_eff),
      .done     (div_o_done),
      .quotient (div_o_q)
   );

   sorm_q16_div #(
      .W (SUM_W)
   ) u_div_mean (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (sum_ff),
      .den      (den_ff),
      .done     (div_m_done),
      .quotient (div_m_q)
   );

   // sum memory: clearing pass after reset, read-modify-write per instance
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = inst_sel_ff;
      mem_wdata = sum_new;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (state_ff == ST_UPDATE && !saturated) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[mem_waddr] <= mem_wdata;
      end
      sum_rd_ff <= sum_mem[inst_eff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         inst_count_ff  <= INST_COUNT_RESET;
         qubit_count_ff <= QUBIT_COUNT_RESET;
         base_ff        <= '0;
         last_chunk_ff  <= 1'b0;
         inst_pos_ff    <= '0;
         sweep_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_INSTANCE_COUNT: inst_count_ff  <= csr_wdata[INST_COUNT_W-1:0];
               CSR_QUBIT_COUNT:    qubit_count_ff <= csr_wdata[QUBIT_COUNT_W-1:0];
               default: ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + IW'(1);
               if (clr_ff == IW'(MAX_INSTANCES - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_bus.valid) begin
                  last_chunk_ff <= is_last;
                  state_ff      <= ST_COUNT;
               end
            end
            ST_COUNT: begin
               if (!pop_busy) begin
                  if (last_chunk_ff) begin
                     state_ff <= ST_READ;
                  end else begin
                     base_ff  <= base_ff + QW'(CHUNK_BITS);
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_READ: begin
               inst_sel_ff <= inst_eff;
               agree_ff    <= (pop_count > q_eff) ? q_eff : pop_count;
               state_ff    <= ST_UPDATE;
            end
            ST_UPDATE: begin
               // once saturated the sums freeze and the mean uses sweep_ff sweeps
               sum_ff       <= saturated ? sum_rd_ff : sum_new;
               den_ff       <= SUM_W'(n_sweeps) * SUM_W'(q_eff);
               sweep_out_ff <= sweep_ff;
               base_ff      <= '0;
               if (inst_sel_ff < last_inst) begin
                  inst_pos_ff <= inst_sel_ff + IW'(1);
               end else begin
                  inst_pos_ff <= '0;
                  if (!saturated) begin
                     sweep_ff <= sweep_ff + SWEEP_BITS'(1);
                  end
               end
               state_ff <= ST_START;
            end
            ST_START: begin
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_o_done && div_m_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp_load) begin
                  rsp_index_ff   <= INDEX_W'(inst_sel_ff);
                  rsp_agree_ff   <= AGREE_W'(agree_ff);
                  rsp_overlap_ff <= div_o_q;
                  rsp_mean_ff    <= div_m_q;
                  rsp_sweep_ff   <= SWEEP_OUT_W'(sweep_out_ff);
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.instance_index   = rsp_index_ff;
   assign rsp_bus.agree_count      = rsp_agree_ff;
   assign rsp_bus.overlap_fraction = rsp_overlap_ff;
   assign rsp_bus.mean_fraction    = rsp_mean_ff;
   assign rsp_bus.sweep_index      = rsp_sweep_ff;

endmodule

// ===== hw/rtl/sorm_agree_serial.sv =====
// bit-serial agreement counter: shifts one chunk out a bit per cycle
// and accumulates the agreeing bits of the current instance; no dependencies

module sorm_agree_serial #(
   parameter int CHUNK_BITS = 64,
   parameter int CNT_W      = 13
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic                             clear,
   input  logic [CHUNK_BITS-1:0]            same_bits,
   input  logic [$clog2(CHUNK_BITS+1)-1:0]  valid_bits,
   output logic                             busy,
   output logic [CNT_W-1:0]                 count
);

   localparam int CW = $clog2(CHUNK_BITS + 1);

   logic [CHUNK_BITS-1:0] shift_ff;
   logic [CW-1:0]         left_ff;
   logic [CNT_W-1:0]      count_ff;

   assign busy  = (left_ff != '0);
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (load) begin
            shift_ff <= same_bits;
            left_ff  <= valid_bits;
         end else if (busy) begin
            shift_ff <= shift_ff >> 1;
            left_ff  <= left_ff - CW'(1);
         end
         if (clear) begin
            count_ff <= '0;
         end else if (!load && busy) begin
            count_ff <= count_ff + CNT_W'(shift_ff[0]);
         end
      end
   end

endmodule

// ===== hw/rtl/sorm_q16_div.sv =====
// restoring divider giving floor(num * 2^16 / den), saturated at 1.0
// one quotient bit per cycle, fixed latency; depends on sorm_pkg

module sorm_q16_div import sorm_pkg::*; #(
   parameter int W = 33
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [W-1:0]       num,
   input  logic [W-1:0]       den,
   output logic               done,
   output logic [RATIO_W-1:0] quotient
);

   localparam int SW = $clog2(FRAC_BITS);

   logic                 busy_ff;
   logic                 done_ff;
   logic                 big_ff;
   logic [SW-1:0]        step_ff;
   logic [W-1:0]         rem_ff;
   logic [W-1:0]         den_ff;
   logic [FRAC_BITS-1:0] quo_ff;

   logic [W:0] rem_sh;
   logic [W:0] rem_sub;
   logic       fits;

   always_comb begin
      rem_sh  = {rem_ff, 1'b0};
      fits    = (rem_sh >= {1'b0, den_ff});
      rem_sub = rem_sh - {1'b0, den_ff};
   end

   assign done     = done_ff;
   assign quotient = big_ff ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, quo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            den_ff  <= den;
            big_ff  <= (num >= den);
            // ratio of one or more: run the steps anyway to keep latency fixed
            rem_ff  <= (num >= den) ? '0 : num;
            quo_ff  <= '0;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= fits ? W'(rem_sub) : W'(rem_sh);
            quo_ff  <= {quo_ff[FRAC_BITS-2:0], fits};
            step_ff <= step_ff + SW'(1);
            if (step_ff == SW'(FRAC_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// ===== sim/tb_spin_overlap_running_mean.sv =====
`timescale 1ns / 1ps
// testbench for spin_overlap_running_mean: drives chunk requests and register writes,
// predicts every instance overlap result and checks it field by field
// depends on sorm_pkg, sorm_ifs and the spin_overlap_running_mean rtl

module tb_spin_overlap_running_mean;
   import sorm_pkg::*;

   localparam int INST_LIMIT    = 256;
   localparam int QUBIT_LIMIT   = 4096;
   localparam int CHUNK_W       = 64;
   localparam int SWEEP_TOP     = (1 << 20) - 1;
   localparam int SETTLE_CYCLES = 150;
   localparam int ITEM_GOAL     = 380;

   typedef struct {
      logic [INDEX_W-1:0]     instance_index;
      logic [AGREE_W-1:0]     agree_count;
      logic [RATIO_W-1:0]     overlap_fraction;
      logic [RATIO_W-1:0]     mean_fraction;
      logic [SWEEP_OUT_W-1:0] sweep_index;
   } overlap_type;

   class overlap_tracker_type;
      logic [INST_COUNT_W-1:0]  inst_count_reg;
      logic [QUBIT_COUNT_W-1:0] qubit_count_reg;
      int unsigned              chunk_pos;
      int unsigned              inst_pos;
      int unsigned              partial;
      int unsigned              sweeps;
      longint unsigned          agree_sums[INST_LIMIT];
      overlap_type              overlaps_due[$];
      int unsigned              mismatch_count;

      function new();
         inst_count_reg  = INST_COUNT_RESET;
         qubit_count_reg = QUBIT_COUNT_RESET;
         chunk_pos       = 0;
         inst_pos        = 0;
         partial         = 0;
         sweeps          = 0;
         mismatch_count  = 0;
         foreach (agree_sums[i]) agree_sums[i] = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_INSTANCE_COUNT: inst_count_reg = value[INST_COUNT_W-1:0];
            CSR_QUBIT_COUNT:    qubit_count_reg = value[QUBIT_COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // floor(num * 2^16 / den), pinned at one when num reaches den
      function longint unsigned q16_floor(longint unsigned num, longint unsigned den);
         if (num >= den) return 64'd65536;
         return (num << 16) / den;
      endfunction

      function void absorb_chunk(logic [SPIN_W-1:0] spins_a, logic [SPIN_W-1:0] spins_b);
         int unsigned       insts, qubits, chunks, base, live_bits, agree, inst, summed;
         logic [SPIN_W-1:0] same;
         bit                full;
         overlap_type       due;
         insts = (inst_count_reg == 0) ? 1 : inst_count_reg;
         if (insts > INST_LIMIT) insts = INST_LIMIT;
         qubits = (qubit_count_reg == 0) ? 1 : qubit_count_reg;
         if (qubits > QUBIT_LIMIT) qubits = QUBIT_LIMIT;
         chunks = (qubits + CHUNK_W - 1) / CHUNK_W;

         base = chunk_pos * CHUNK_W;
         live_bits = (base >= qubits) ? 0 : qubits - base;
         if (live_bits > CHUNK_W) live_bits = CHUNK_W;
         same = ~(spins_a ^ spins_b);
         if (live_bits < CHUNK_W) same &= (64'd1 << live_bits) - 64'd1;
         partial += $countones(same);

         if (chunk_pos + 1 < chunks) begin
            chunk_pos++;
            return;
         end

         // positions left beyond a shrunk setting count as the last one
         agree = (partial > qubits) ? qubits : partial;
         inst = (inst_pos >= insts) ? insts - 1 : inst_pos;
         full = (sweeps >= SWEEP_TOP);
         if (!full) agree_sums[inst] += agree;
         summed = full ? sweeps : sweeps + 1;

         due.instance_index   = INDEX_W'(inst);
         due.agree_count      = AGREE_W'(agree);
         due.overlap_fraction = RATIO_W'(q16_floor(agree, qubits));
         due.mean_fraction    = RATIO_W'(q16_floor(agree_sums[inst], 64'(summed) * qubits));
         due.sweep_index      = SWEEP_OUT_W'(sweeps);
         overlaps_due.insert(overlaps_due.size(), due);

         chunk_pos = 0;
         partial = 0;
         if (inst + 1 < insts) begin
            inst_pos = inst + 1;
         end else begin
            inst_pos = 0;
            if (!full) sweeps++;
         end
      endfunction

      function void compare_field(string label, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         end
      endfunction

      function void match_overlap(overlap_type got);
         overlap_type want;
         if (overlaps_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result for instance %0d, agree %0d", $time,
                     got.instance_index, got.agree_count);
            return;
         end
         want = overlaps_due.pop_front();
         compare_field("instance_index", want.instance_index, got.instance_index);
         compare_field("agree_count", want.agree_count, got.agree_count);
         compare_field("overlap_fraction", want.overlap_fraction, got.overlap_fraction);
         compare_field("mean_fraction", want.mean_fraction, got.mean_fraction);
         compare_field("sweep_index", want.sweep_index, got.sweep_index);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit                    req_gaps_on = 1'b1;
   bit                    rsp_gaps_on = 1'b1;

   sorm_req_if req_bus ();
   sorm_rsp_if rsp_bus ();

   overlap_tracker_type tracker = new();

   spin_overlap_running_mean DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned draw_gap(bit enabled);
      return enabled ? $urandom_range(0, 16) : 0;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
         tracker.absorb_chunk(req_bus.spins_a, req_bus.spins_b);
   end

   always @(posedge clock) begin : watch_results
      overlap_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.instance_index   = rsp_bus.instance_index;
         got.agree_count      = rsp_bus.agree_count;
         got.overlap_fraction = rsp_bus.overlap_fraction;
         got.mean_fraction    = rsp_bus.mean_fraction;
         got.sweep_index      = rsp_bus.sweep_index;
         tracker.match_overlap(got);
      end
   end

   initial begin : drive_rsp_ready
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = draw_gap(rsp_gaps_on);
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1 || reset);
      end
   end

   // valid stays high after acceptance until the next request or a hold
   task automatic send_spins(logic [SPIN_W-1:0] spins_a, logic [SPIN_W-1:0] spins_b);
      int unsigned gap;
      gap = draw_gap(req_gaps_on);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.spins_a <= spins_a;
      req_bus.spins_b <= spins_b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic hold_requests();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tracker.overlaps_due.size() != 0) @(posedge clock);
   endtask

   // a chunk that causes no result may still be in flight
   task automatic settle();
      hold_requests();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(logic [CSR_DATA_W-1:0] insts, logic [CSR_DATA_W-1:0] qubits);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_INSTANCE_COUNT;
      csr_wdata    <= insts;
      @(negedge clock);
      csr_index    <= CSR_QUBIT_COUNT;
      csr_wdata    <= qubits;
      @(negedge clock);
      csr_write_en <= 1'b0;
      tracker.write_reg(CSR_INSTANCE_COUNT, insts);
      tracker.write_reg(CSR_QUBIT_COUNT, qubits);
   endtask

   task automatic run_burst(logic [CSR_DATA_W-1:0] insts, logic [CSR_DATA_W-1:0] qubits,
                            int unsigned count);
      logic [SPIN_W-1:0] spins_a, spins_b;
      settle();
      set_config(insts, qubits);
      repeat (count) begin
         spins_a = {$urandom, $urandom};
         case ($urandom_range(0, 5))
            0: spins_b = spins_a;
            1: spins_b = ~spins_a;
            2: spins_b = spins_a ^ (64'd1 << $urandom_range(0, 63));
            3: begin
               spins_a = $urandom_range(0, 1) ? '1 : '0;
               spins_b = {$urandom, $urandom};
            end
            default: spins_b = {$urandom, $urandom};
         endcase
         send_spins(spins_a, spins_b);
         if ($urandom_range(0, 24) == 0) hold_requests();
      end
   endtask

   initial begin : stimulus
      logic [SPIN_W-1:0]     pick;
      logic [CSR_DATA_W-1:0] insts, qubits;
      int unsigned           burst, items_sent;
      req_bus.valid   = 1'b0;
      req_bus.spins_a = '0;
      req_bus.spins_b = '0;
      csr_write_en    = 1'b0;
      csr_index       = CSR_INSTANCE_COUNT;
      csr_wdata       = '0;
      reset           = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: one instance of 64 spins
      send_spins('0, '0);
      send_spins('1, '0);
      send_spins('1, '1);
      send_spins({32{2'b01}}, {32{2'b10}});
      pick = {$urandom, $urandom};
      send_spins(pick, pick ^ 64'd1);
      send_spins(pick, pick ^ (64'd1 << 63));

      // zero registers act as one instance of one spin, upper bits ignored
      settle();
      set_config('0, '0);
      send_spins('0, '0);
      send_spins(64'd1, '0);
      send_spins(64'hFFFF_FFFF_FFFF_FFFE, '0);

      // 65 spins leave a single live bit in the second chunk
      settle();
      set_config(13'd3, 13'd65);
      pick = {$urandom, $urandom};
      send_spins(pick, pick);
      send_spins(64'hFFFF_FFFF_FFFF_FFFE, '0);
      send_spins(pick, ~pick);
      send_spins(64'd1, '0);
      send_spins(pick, {$urandom, $urandom});
      send_spins(64'hFFFF_FFFF_FFFF_FFFE, '0);
      send_spins(pick, pick ^ 64'd1);
      send_spins(64'd1, '0);

      // shrink settings mid-instance and mid-sweep
      settle();
      set_config(13'd2, 13'd127);
      send_spins({$urandom, $urandom}, {$urandom, $urandom});
      settle();
      set_config(13'd1, 13'd64);
      send_spins('0, '0);

      // a full sweep over the most instances, then the most spins
      items_sent = 0;
      run_burst(13'h1FFF, 13'd1, 258);
      run_burst(13'd2, 13'h1FFF, 67);
      items_sent = 325;

      while (items_sent < ITEM_GOAL) begin
         case ($urandom_range(0, 9))
            0: insts = 13'd0;
            1: insts = 13'd1;
            2: insts = 13'd256;
            3: insts = 13'h1FFF;
            4: insts = 13'($urandom_range(257, 8191));
            default: insts = 13'($urandom_range(2, 6));
         endcase
         case ($urandom_range(0, 11))
            0: qubits = 13'd0;
            1: qubits = 13'd1;
            2: qubits = 13'd63;
            3: qubits = 13'd64;
            4: qubits = 13'd65;
            5: qubits = 13'd128;
            6: qubits = 13'($urandom_range(129, 1024));
            7: qubits = $urandom_range(0, 1) ? 13'd4096 : 13'h1FFF;
            default: qubits = 13'($urandom_range(2, 200));
         endcase
         burst = $urandom_range(10, 50);
         settle();
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         run_burst(insts, qubits, burst);
         items_sent += burst;
      end

      settle();
      if (tracker.mismatch_count == 0 && tracker.overlaps_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/sorm_pkg.sv
hw/rtl/sorm_ifs.sv
hw/rtl/sorm_agree_serial.sv
hw/rtl/sorm_q16_div.sv
hw/rtl/spin_overlap_running_mean.sv
sim/tb_spin_overlap_running_mean.sv
